FILE: sv/pdh_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the pair distance histogram.
// No dependencies; used by the top level and the checker.
package pdh_pkg;

   localparam int MAX_PARTICLES = 1024;
   localparam int HIST_DEPTH    = 256;

   localparam int PIDX_W  = $clog2(MAX_PARTICLES);   // store slot address
   localparam int PCNT_W  = PIDX_W + 1;              // particle count
   localparam int BIN_W   = $clog2(HIST_DEPTH);      // histogram address
   localparam int USED_W  = BIN_W + 1;               // bins in use
   localparam int COORD_W = 32;
   localparam int LEN_W   = 31;
   localparam int CNT_W   = 32;
   localparam int SQ_W    = 2 * COORD_W;             // one squared axis
   localparam int SUM_W   = SQ_W + 2;                // sum of three squares
   localparam int ROOT_W  = 34;                      // root bits produced
   localparam int RAD_W   = 2 * ROOT_W;              // padded radicand
   localparam int REM_W   = ROOT_W + 2;              // root remainder
   localparam int STEP_W  = $clog2(ROOT_W);

   localparam int REQ_DATA_W = 120;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0]  BOX_RESET      = LEN_W'(655360);
   localparam logic [LEN_W-1:0]  BIN_WIDTH_RESET = LEN_W'(6554);
   localparam logic [USED_W-1:0] BINS_USED_RESET = USED_W'(256);
   localparam logic [CNT_W-1:0]  COUNT_INC      = CNT_W'(2);

   // request modes
   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_PASS  = 2'd1,
      MODE_READ  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_USED = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PCOUNT    = 3'd5;

   // response status
   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_BIN,
      ST_READ_I,
      ST_LATCH_I,
      ST_FETCH_J,
      ST_DIFF,
      ST_SQUARE,
      ST_SUM,
      ST_SQRT,
      ST_DIV,
      ST_HIST_RD,
      ST_HIST_WR,
      ST_NEXT
   } state_type;

   typedef struct packed {
      logic               fixed;
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } particle_type;

   localparam int PART_W = $bits(particle_type);

   // minimum-image magnitude on one axis, one wrap at most
   function automatic logic [COORD_W-1:0] axis_mag(
      input logic [COORD_W-1:0] a,
      input logic [COORD_W-1:0] b,
      input logic [LEN_W-1:0]   len
   );
      logic signed [COORD_W+2:0] d;
      logic signed [COORD_W+2:0] d2;
      logic signed [COORD_W+2:0] l;
      d  = (COORD_W+3)'(signed'(a)) - (COORD_W+3)'(signed'(b));
      l  = signed'({4'b0000, len});
      d2 = d <<< 1;
      if (d2 > l) begin
         d = d - l;
      end else if (d2 < -l) begin
         d = d + l;
      end
      if (d < 0) begin
         d = -d;
      end
      return d[COORD_W-1:0];
   endfunction

endpackage

FILE: sv/pdh_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

FILE: sv/pair_distance_histogram.sv
`timescale 1ns / 1ps
// Pair distance histogram top level: particle store, pair pass sequencer,
// histogram memory. Uses pdh_pkg and pdh_ram.

// Each request gives one response. A load or a clear is answered from the idle
// state and a read through ST_READ_BIN, so loads stream at one per cycle while
// responses are taken. A pair pass walks all unordered pairs of the first
// particle_count slots: a pair with a fixed particle goes on to the next pair
// after the minimum-image differences, any other pair goes through the
// bit-serial square root, the bit-serial divide and the read-modify-write of
// the histogram memory. The histogram is cleared at reset and by a clear
// request through per-bin valid flags. Unwritten particle slots read as
// undefined.
module pair_distance_histogram (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = particle_index[9:0], pos_x[41:10], pos_y[73:42],
   //          pos_z[105:74], pinned[106], bin_index[114:107], zero above
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pdh_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [1:0]                        req_tuser,  // mode[1:0]
   // response
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pdh_pkg::CNT_W-1:0]         rsp_tdata,  // bin_count[31:0]
   output logic [0:0]                        rsp_tuser,  // status[0]
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pdh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pdh_pkg::CSR_DATA_W-1:0]    csr_data
);

   // request fields
   pdh_pkg::mode_type                 req_mode;
   logic [pdh_pkg::PIDX_W-1:0]        req_particle_index;
   logic signed [pdh_pkg::COORD_W-1:0] req_pos_x;
   logic signed [pdh_pkg::COORD_W-1:0] req_pos_y;
   logic signed [pdh_pkg::COORD_W-1:0] req_pos_z;
   logic                              req_pinned;
   logic [pdh_pkg::BIN_W-1:0]         req_bin_index;

   assign req_mode           = pdh_pkg::mode_type'(req_tuser);
   assign req_particle_index = req_tdata[9:0];
   assign req_pos_x          = signed'(req_tdata[41:10]);
   assign req_pos_y          = signed'(req_tdata[73:42]);
   assign req_pos_z          = signed'(req_tdata[105:74]);
   assign req_pinned         = req_tdata[106];
   assign req_bin_index      = req_tdata[114:107];

   // configuration registers
   logic [pdh_pkg::LEN_W-1:0]  box_x_ff, box_y_ff, box_z_ff, bin_width_ff;
   logic [pdh_pkg::USED_W-1:0] bins_used_ff;
   logic [pdh_pkg::PCNT_W-1:0] pcount_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff     <= pdh_pkg::BOX_RESET;
         box_y_ff     <= pdh_pkg::BOX_RESET;
         box_z_ff     <= pdh_pkg::BOX_RESET;
         bin_width_ff <= pdh_pkg::BIN_WIDTH_RESET;
         bins_used_ff <= pdh_pkg::BINS_USED_RESET;
         pcount_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pdh_pkg::CSR_BOX_X:     box_x_ff     <= csr_data[pdh_pkg::LEN_W-1:0];
            pdh_pkg::CSR_BOX_Y:     box_y_ff     <= csr_data[pdh_pkg::LEN_W-1:0];
            pdh_pkg::CSR_BOX_Z:     box_z_ff     <= csr_data[pdh_pkg::LEN_W-1:0];
            pdh_pkg::CSR_BIN_WIDTH: bin_width_ff <= csr_data[pdh_pkg::LEN_W-1:0];
            pdh_pkg::CSR_BINS_USED: bins_used_ff <= csr_data[pdh_pkg::USED_W-1:0];
            pdh_pkg::CSR_PCOUNT:    pcount_ff    <= csr_data[pdh_pkg::PCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective bin width and bins in use
   logic [pdh_pkg::LEN_W-1:0]  width_eff;
   logic [pdh_pkg::USED_W-1:0] used_eff;

   assign width_eff = (bin_width_ff == '0) ? pdh_pkg::LEN_W'(1) : bin_width_ff;
   assign used_eff  = (bins_used_ff > pdh_pkg::USED_W'(pdh_pkg::HIST_DEPTH))
                      ? pdh_pkg::USED_W'(pdh_pkg::HIST_DEPTH) : bins_used_ff;

   // state and datapath registers
   pdh_pkg::state_type state_ff, state_in;
   logic [pdh_pkg::PCNT_W-1:0]  i_ff, i_in, j_ff, j_in;
   pdh_pkg::particle_type       pi_ff, pi_in;
   logic [pdh_pkg::COORD_W-1:0] mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic [pdh_pkg::SQ_W-1:0]    sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [pdh_pkg::RAD_W-1:0]   rad_ff, rad_in;
   logic [pdh_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [pdh_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [pdh_pkg::ROOT_W-1:0]  quo_ff, quo_in;
   logic [pdh_pkg::LEN_W-1:0]   drem_ff, drem_in;
   logic [pdh_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [pdh_pkg::BIN_W-1:0]   bin_ff, bin_in;
   logic [pdh_pkg::HIST_DEPTH-1:0] hvalid_ff, hvalid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pdh_pkg::CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                        rsp_status_ff, rsp_status_in;

   // memory ports
   logic                        st_wr_en;
   logic [pdh_pkg::PIDX_W-1:0]  st_rd_addr;
   pdh_pkg::particle_type       st_wr_data, st_rd_data;
   logic                        hi_wr_en;
   logic [pdh_pkg::BIN_W-1:0]   hi_rd_addr;
   logic [pdh_pkg::CNT_W-1:0]   hi_wr_data, hi_rd_data, hist_val;

   logic req_accept;

   assign req_tready = (state_ff == pdh_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign st_wr_en   = req_accept && (req_mode == pdh_pkg::MODE_LOAD);
   assign st_wr_data = '{fixed: req_pinned, z: req_pos_z, y: req_pos_y, x: req_pos_x};
   assign st_rd_addr = (state_ff == pdh_pkg::ST_READ_I) ? i_ff[pdh_pkg::PIDX_W-1:0]
                                                        : j_ff[pdh_pkg::PIDX_W-1:0];

   // histogram read address: request bin when idle, computed bin before update
   assign hi_rd_addr = (state_ff == pdh_pkg::ST_IDLE)    ? req_bin_index :
                       (state_ff == pdh_pkg::ST_HIST_RD) ? quo_ff[pdh_pkg::BIN_W-1:0]
                                                         : bin_ff;
   assign hist_val   = hvalid_ff[bin_ff] ? hi_rd_data : '0;
   assign hi_wr_en   = (state_ff == pdh_pkg::ST_HIST_WR);
   assign hi_wr_data = (hist_val > ~pdh_pkg::COUNT_INC) ? '1 : hist_val + pdh_pkg::COUNT_INC;

   pdh_ram #(
      .WIDTH (pdh_pkg::PART_W),
      .DEPTH (pdh_pkg::MAX_PARTICLES)
   ) u_store (
      .clock      (clock),
      .wr_en      (st_wr_en),
      .wr_addr    (req_particle_index),
      .wr_data    (st_wr_data),
      .rd_addr    (st_rd_addr),
      .rd_data_ff (st_rd_data)
   );

   pdh_ram #(
      .WIDTH (pdh_pkg::CNT_W),
      .DEPTH (pdh_pkg::HIST_DEPTH)
   ) u_hist (
      .clock      (clock),
      .wr_en      (hi_wr_en),
      .wr_addr    (bin_ff),
      .wr_data    (hi_wr_data),
      .rd_addr    (hi_rd_addr),
      .rd_data_ff (hi_rd_data)
   );

   // square root and divide steps
   logic [pdh_pkg::REM_W+1:0] sq_rem_sh, sq_trial;
   logic [pdh_pkg::LEN_W:0]   dv_rem_sh;
   logic [pdh_pkg::SUM_W-1:0] sq_sum;

   assign sq_rem_sh = {rem_ff, rad_ff[pdh_pkg::RAD_W-1 -: 2]};
   assign sq_trial  = {2'b00, root_ff, 2'b01};
   assign dv_rem_sh = {drem_ff, quo_ff[pdh_pkg::ROOT_W-1]};
   assign sq_sum    = pdh_pkg::SUM_W'(sx_ff) + pdh_pkg::SUM_W'(sy_ff)
                    + pdh_pkg::SUM_W'(sz_ff);

   // sequencer: next state, datapath and response
   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      pi_in         = pi_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      mz_in         = mz_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      sz_in         = sz_ff;
      rad_in        = rad_ff;
      root_in       = root_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      drem_in       = drem_ff;
      step_in       = step_ff;
      bin_in        = bin_ff;
      hvalid_in     = hvalid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         pdh_pkg::ST_IDLE: begin
            if (req_accept) begin
               rsp_count_in  = '0;
               rsp_status_in = pdh_pkg::STATUS_DONE;
               unique case (req_mode)
                  pdh_pkg::MODE_LOAD: begin
                     rsp_valid_in = 1'b1;
                  end
                  pdh_pkg::MODE_CLEAR: begin
                     hvalid_in    = '0;
                     rsp_valid_in = 1'b1;
                  end
                  pdh_pkg::MODE_READ: begin
                     bin_in   = req_bin_index;
                     state_in = pdh_pkg::ST_READ_BIN;
                  end
                  pdh_pkg::MODE_PASS: begin
                     if (pcount_ff > pdh_pkg::PCNT_W'(pdh_pkg::MAX_PARTICLES)) begin
                        rsp_status_in = pdh_pkg::STATUS_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else if (pcount_ff < pdh_pkg::PCNT_W'(2)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        i_in     = '0;
                        j_in     = pdh_pkg::PCNT_W'(1);
                        state_in = pdh_pkg::ST_READ_I;
                     end
                  end
                  default: ;
               endcase
            end
         end
         pdh_pkg::ST_READ_BIN: begin
            rsp_count_in = hist_val;
            rsp_valid_in = 1'b1;
            state_in     = pdh_pkg::ST_IDLE;
         end
         pdh_pkg::ST_READ_I: begin
            state_in = pdh_pkg::ST_LATCH_I;
         end
         pdh_pkg::ST_LATCH_I: begin
            pi_in    = st_rd_data;
            state_in = pdh_pkg::ST_DIFF;
         end
         pdh_pkg::ST_FETCH_J: begin
            state_in = pdh_pkg::ST_DIFF;
         end
         pdh_pkg::ST_DIFF: begin
            mx_in = pdh_pkg::axis_mag(pi_ff.x, st_rd_data.x, box_x_ff);
            my_in = pdh_pkg::axis_mag(pi_ff.y, st_rd_data.y, box_y_ff);
            mz_in = pdh_pkg::axis_mag(pi_ff.z, st_rd_data.z, box_z_ff);
            if (pi_ff.fixed || st_rd_data.fixed) begin
               state_in = pdh_pkg::ST_NEXT;
            end else begin
               state_in = pdh_pkg::ST_SQUARE;
            end
         end
         pdh_pkg::ST_SQUARE: begin
            sx_in    = mx_ff * mx_ff;
            sy_in    = my_ff * my_ff;
            sz_in    = mz_ff * mz_ff;
            state_in = pdh_pkg::ST_SUM;
         end
         pdh_pkg::ST_SUM: begin
            rad_in   = pdh_pkg::RAD_W'(sq_sum);
            root_in  = '0;
            rem_in   = '0;
            step_in  = pdh_pkg::STEP_W'(pdh_pkg::ROOT_W - 1);
            state_in = pdh_pkg::ST_SQRT;
         end
         pdh_pkg::ST_SQRT: begin
            // one root bit per cycle, two radicand bits consumed
            rad_in = rad_ff << 2;
            if (sq_rem_sh >= sq_trial) begin
               rem_in  = pdh_pkg::REM_W'(sq_rem_sh - sq_trial);
               root_in = {root_ff[pdh_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = pdh_pkg::REM_W'(sq_rem_sh);
               root_in = {root_ff[pdh_pkg::ROOT_W-2:0], 1'b0};
            end
            if (step_ff == '0) begin
               // hand the finished root to the divider
               quo_in   = root_in;
               drem_in  = '0;
               step_in  = pdh_pkg::STEP_W'(pdh_pkg::ROOT_W - 1);
               state_in = pdh_pkg::ST_DIV;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         pdh_pkg::ST_DIV: begin
            // restoring divide of the root by the bin width, one bit a cycle
            if (dv_rem_sh >= {1'b0, width_eff}) begin
               drem_in = pdh_pkg::LEN_W'(dv_rem_sh - {1'b0, width_eff});
               quo_in  = {quo_ff[pdh_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               drem_in = pdh_pkg::LEN_W'(dv_rem_sh);
               quo_in  = {quo_ff[pdh_pkg::ROOT_W-2:0], 1'b0};
            end
            if (step_ff == '0) begin
               state_in = pdh_pkg::ST_HIST_RD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         pdh_pkg::ST_HIST_RD: begin
            if (quo_ff < pdh_pkg::ROOT_W'(used_eff)) begin
               bin_in   = quo_ff[pdh_pkg::BIN_W-1:0];
               state_in = pdh_pkg::ST_HIST_WR;
            end else begin
               state_in = pdh_pkg::ST_NEXT;
            end
         end
         pdh_pkg::ST_HIST_WR: begin
            hvalid_in[bin_ff] = 1'b1;
            state_in          = pdh_pkg::ST_NEXT;
         end
         pdh_pkg::ST_NEXT: begin
            if ((pdh_pkg::PCNT_W+1)'(j_ff) + 1'b1 < (pdh_pkg::PCNT_W+1)'(pcount_ff)) begin
               j_in     = j_ff + 1'b1;
               state_in = pdh_pkg::ST_FETCH_J;
            end else if ((pdh_pkg::PCNT_W+1)'(i_ff) + 2'd2
                         < (pdh_pkg::PCNT_W+1)'(pcount_ff)) begin
               i_in     = i_ff + 1'b1;
               j_in     = i_ff + pdh_pkg::PCNT_W'(2);
               state_in = pdh_pkg::ST_READ_I;
            end else begin
               rsp_count_in  = '0;
               rsp_status_in = pdh_pkg::STATUS_DONE;
               rsp_valid_in  = 1'b1;
               state_in      = pdh_pkg::ST_IDLE;
            end
         end
         default: state_in = pdh_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdh_pkg::ST_IDLE;
         hvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hvalid_ff    <= hvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      pi_ff         <= pi_in;
      mx_ff         <= mx_in;
      my_ff         <= my_in;
      mz_ff         <= mz_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      sz_ff         <= sz_in;
      rad_ff        <= rad_in;
      root_ff       <= root_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      drem_ff       <= drem_in;
      step_ff       <= step_in;
      bin_ff        <= bin_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

FILE: sv/pdh_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the pair distance histogram, bound to the top level.
// Uses pdh_pkg.
module pdh_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [1:0]                     req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pdh_pkg::CNT_W-1:0]      rsp_tdata,
   input logic [0:0]                     rsp_tuser
);

   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   // a pending response is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // a load request answers in the next cycle with a zero count
   a_load_next: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == pdh_pkg::MODE_LOAD |=> rsp_tvalid && rsp_tdata == '0)
      else $error("load request not answered next cycle");

   // a clear request answers in the next cycle with a zero count
   a_clear_next: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == pdh_pkg::MODE_CLEAR |=> rsp_tvalid && rsp_tdata == '0)
      else $error("clear request not answered next cycle");

   // an error status never carries a count
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("nonzero count with error status");

endmodule

bind pair_distance_histogram pdh_checker u_pdh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for pair_distance_histogram: loads, pair passes, bin
// reads and clears against a local pair histogram predictor. Uses pdh_pkg.
module tb_top;

   localparam int  ITEM_TARGET = 1300;
   localparam longint CYCLE_LIMIT = 6000000;

   // predictor of the histogram block plus the queue of awaited responses
   class pair_hist_checker;
      logic [pdh_pkg::LEN_W-1:0]   box_len [3];
      logic [pdh_pkg::LEN_W-1:0]   width;
      logic [pdh_pkg::USED_W-1:0]  used;
      logic [pdh_pkg::PCNT_W-1:0]  pcount;
      logic [pdh_pkg::COORD_W-1:0] pos [pdh_pkg::MAX_PARTICLES][3];
      logic                        fixed_flag [pdh_pkg::MAX_PARTICLES];
      logic [pdh_pkg::CNT_W-1:0]   hist [pdh_pkg::HIST_DEPTH];
      logic [pdh_pkg::CNT_W-1:0]   count_q [$];
      logic                        status_q [$];
      int                          failures;

      function new();
         box_len[0] = pdh_pkg::BOX_RESET;
         box_len[1] = pdh_pkg::BOX_RESET;
         box_len[2] = pdh_pkg::BOX_RESET;
         width      = pdh_pkg::BIN_WIDTH_RESET;
         used       = pdh_pkg::BINS_USED_RESET;
         pcount     = '0;
         failures   = 0;
         foreach (hist[b]) hist[b] = '0;
      endfunction

      function void write_reg(logic [pdh_pkg::CSR_IDX_W-1:0] idx,
                              logic [pdh_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            pdh_pkg::CSR_BOX_X:     box_len[0] = val[pdh_pkg::LEN_W-1:0];
            pdh_pkg::CSR_BOX_Y:     box_len[1] = val[pdh_pkg::LEN_W-1:0];
            pdh_pkg::CSR_BOX_Z:     box_len[2] = val[pdh_pkg::LEN_W-1:0];
            pdh_pkg::CSR_BIN_WIDTH: width = val[pdh_pkg::LEN_W-1:0];
            pdh_pkg::CSR_BINS_USED: used = val[pdh_pkg::USED_W-1:0];
            pdh_pkg::CSR_PCOUNT:    pcount = val[pdh_pkg::PCNT_W-1:0];
            default: ;
         endcase
      endfunction

      // minimum-image magnitude, one wrap at most
      function logic [69:0] wrap_mag(logic [pdh_pkg::COORD_W-1:0] a,
                                     logic [pdh_pkg::COORD_W-1:0] b,
                                     logic [pdh_pkg::LEN_W-1:0] len);
         longint d;
         longint l;
         d = longint'(signed'(a)) - longint'(signed'(b));
         l = longint'(len);
         if (2 * d > l) begin
            d = d - l;
         end else if (2 * d < -l) begin
            d = d + l;
         end
         if (d < 0) d = -d;
         return 70'(d);
      endfunction

      function logic [69:0] int_sqrt(logic [69:0] v);
         logic [69:0] r;
         logic [69:0] t;
         r = '0;
         for (int bit_i = 34; bit_i >= 0; bit_i--) begin
            t = r | (70'd1 << bit_i);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      function void pair_pass();
         logic [69:0] sum;
         logic [69:0] m;
         logic [69:0] bin;
         logic [69:0] w;
         int          lim;
         w   = (width == 0) ? 70'd1 : 70'(width);
         lim = (used > pdh_pkg::HIST_DEPTH) ? pdh_pkg::HIST_DEPTH : int'(used);
         for (int i = 0; i + 1 < int'(pcount); i++) begin
            for (int j = i + 1; j < int'(pcount); j++) begin
               sum = '0;
               for (int k = 0; k < 3; k++) begin
                  m   = wrap_mag(pos[i][k], pos[j][k], box_len[k]);
                  sum = sum + m * m;
               end
               bin = int_sqrt(sum) / w;
               if (bin < 70'(lim) && !fixed_flag[i] && !fixed_flag[j]) begin
                  hist[bin] = (hist[bin] > 32'hFFFF_FFFD) ? 32'hFFFF_FFFF
                                                          : hist[bin] + pdh_pkg::COUNT_INC;
               end
            end
         end
      endfunction

      // work out the response of an accepted request
      function void note_request(pdh_pkg::mode_type mode,
                                 logic [pdh_pkg::REQ_DATA_W-1:0] d);
         logic [pdh_pkg::CNT_W-1:0] cnt;
         logic                      st;
         int                        slot;
         cnt  = '0;
         st   = pdh_pkg::STATUS_DONE;
         slot = int'(d[9:0]);
         case (mode)
            pdh_pkg::MODE_LOAD: begin
               pos[slot][0]     = d[41:10];
               pos[slot][1]     = d[73:42];
               pos[slot][2]     = d[105:74];
               fixed_flag[slot] = d[106];
            end
            pdh_pkg::MODE_PASS: begin
               if (pcount > pdh_pkg::MAX_PARTICLES) st = pdh_pkg::STATUS_RANGE;
               else pair_pass();
            end
            pdh_pkg::MODE_READ:  cnt = hist[d[114:107]];
            pdh_pkg::MODE_CLEAR: foreach (hist[b]) hist[b] = '0;
         endcase
         count_q.push_back(cnt);
         status_q.push_back(st);
      endfunction

      function void check_response(logic [pdh_pkg::CNT_W-1:0] cnt, logic st);
         logic [pdh_pkg::CNT_W-1:0] exp_cnt;
         logic                      exp_st;
         if (count_q.size() == 0) begin
            $error("response with none awaited: bin_count %0d status %0d", cnt, st);
            failures++;
            return;
         end
         exp_cnt = count_q.pop_front();
         exp_st  = status_q.pop_front();
         if (cnt !== exp_cnt) begin
            $error("bin_count expected %0d actual %0d", exp_cnt, cnt);
            failures++;
         end
         if (st !== exp_st) begin
            $error("status expected %0d actual %0d", exp_st, st);
            failures++;
         end
      endfunction

      function int awaited();
         return count_q.size();
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [pdh_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [1:0]                     req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [pdh_pkg::CNT_W-1:0]      rsp_tdata;
   logic [0:0]                     rsp_tuser;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [pdh_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pdh_pkg::CSR_DATA_W-1:0] csr_data;

   pair_hist_checker hist_chk = new();
   int     tx_idle_pct = 20;
   int     rx_idle_pct = 86;
   bit     stall_req   = 0;
   int     items_sent  = 0;
   longint cycles      = 0;

   pair_distance_histogram dut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // response side: random back-pressure plus one long hold-off
   initial begin
      int  hold;
      bit  stall_done;
      hold       = 0;
      stall_done = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_req && !stall_done) begin
            stall_done = 1;
            hold       = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) hist_chk.check_response(rsp_tdata, rsp_tuser[0]);
   end

   // run watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_reg(logic [pdh_pkg::CSR_IDX_W-1:0] idx,
                            logic [pdh_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      hist_chk.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // leaves valid high after the request is taken
   task automatic send_request(pdh_pkg::mode_type mode, int slot,
                               logic [pdh_pkg::COORD_W-1:0] x,
                               logic [pdh_pkg::COORD_W-1:0] y,
                               logic [pdh_pkg::COORD_W-1:0] z,
                               logic fx, logic [pdh_pkg::BIN_W-1:0] bin);
      logic [pdh_pkg::REQ_DATA_W-1:0] d;
      d = {5'b0, bin, fx, z, y, x, slot[9:0]};
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      hist_chk.note_request(mode, d);
      items_sent++;
      if (items_sent == ITEM_TARGET / 3) begin
         tx_idle_pct = 86;
         rx_idle_pct = 20;
      end else if (items_sent == 2 * ITEM_TARGET / 3) begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
   endtask

   task automatic go_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (hist_chk.awaited() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_regs(int bx, int by, int bz, int w, int u, int n);
      go_idle();
      write_reg(pdh_pkg::CSR_BOX_X, bx);
      write_reg(pdh_pkg::CSR_BOX_Y, by);
      write_reg(pdh_pkg::CSR_BOX_Z, bz);
      write_reg(pdh_pkg::CSR_BIN_WIDTH, w);
      write_reg(pdh_pkg::CSR_BINS_USED, u);
      write_reg(pdh_pkg::CSR_PCOUNT, n);
   endtask

   function automatic logic [pdh_pkg::COORD_W-1:0] pick_coord();
      case ($urandom_range(7))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         2: return 32'($urandom_range(26216)) - 32'd13108;
         default: return 32'($urandom_range(655360)) - 32'd327680;
      endcase
   endfunction

   task automatic send_load(int slot);
      send_request(pdh_pkg::MODE_LOAD, slot, pick_coord(), pick_coord(), pick_coord(),
                   ($urandom_range(5) == 0), pdh_pkg::BIN_W'($urandom));
   endtask

   task automatic send_read(int bin);
      send_request(pdh_pkg::MODE_READ, $urandom_range(1023), $urandom, $urandom, $urandom,
                   1'($urandom_range(1)), pdh_pkg::BIN_W'(bin));
   endtask

   task automatic send_simple(pdh_pkg::mode_type mode);
      send_request(mode, $urandom_range(1023), $urandom, $urandom, $urandom,
                   1'($urandom_range(1)), pdh_pkg::BIN_W'($urandom));
   endtask

   // one frame: fill the first n slots, pass when allowed, read back some bins
   task automatic run_frame(int n, bit legal);
      if ($urandom_range(3) == 0) send_simple(pdh_pkg::MODE_CLEAR);
      for (int s = 0; s < n; s++) begin
         send_load(s);
         if ($urandom_range(4) == 0) send_load($urandom_range(1023));
         if ($urandom_range(6) == 0) send_read($urandom);
      end
      if (legal) send_simple(pdh_pkg::MODE_PASS);
      repeat ($urandom_range(4, 8)) send_read($urandom_range(3) == 0 ? $urandom : $urandom_range(99));
   endtask

   initial begin
      int n;
      int bx;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = pdh_pkg::MODE_LOAD;
      csr_valid  = 1'b0;
      csr_index  = pdh_pkg::CSR_BOX_X;
      csr_data   = '0;
      reset      = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: near pairs, a wrapped pair, a fixed particle, extremes
      set_regs(655360, 655360, 655360, 6554, 256, 5);
      send_request(pdh_pkg::MODE_LOAD, 0, 32'd0, 32'd0, 32'd0, 1'b0, 8'd0);
      send_request(pdh_pkg::MODE_LOAD, 1, 32'd65536, 32'd0, 32'd0, 1'b0, 8'd0);
      send_request(pdh_pkg::MODE_LOAD, 2, 32'd321126, 32'd0, 32'd0, 1'b0, 8'd0);
      send_request(pdh_pkg::MODE_LOAD, 3, -32'sd321126, 32'd0, 32'd0, 1'b0, 8'd0);
      send_request(pdh_pkg::MODE_LOAD, 4, 32'd6554, 32'd6554, 32'd6554, 1'b1, 8'd0);
      send_request(pdh_pkg::MODE_LOAD, 1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                   1'b1, 8'hFF);
      send_simple(pdh_pkg::MODE_PASS);
      send_read(0);
      send_read(4);
      send_read(10);
      send_read(49);
      send_read(255);
      send_simple(pdh_pkg::MODE_CLEAR);
      send_read(10);
      send_simple(pdh_pkg::MODE_PASS);
      send_simple(pdh_pkg::MODE_PASS);
      send_read(10);

      // register extremes, then random settings
      set_regs(1, 1, 1, 1, 1, 0);
      run_frame(3, 1);
      set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 511, 1);
      run_frame(3, 1);
      set_regs(0, 0, 0, 0, 0, 2047);
      run_frame(3, 1);
      set_regs(655360, 655360, 655360, 1, 256, 1025);
      run_frame(2, 1);
      set_regs(655360, 655360, 655360, 6554, 256, 1024);
      run_frame(4, 0);

      // long hold-off on the response side during a load stream
      stall_req = 1;
      for (int s = 0; s < 60; s++) send_load($urandom_range(1023));

      while (items_sent < ITEM_TARGET) begin
         n  = ($urandom_range(7) == 0) ? $urandom_range(12, 16) : $urandom_range(2, 8);
         bx = ($urandom_range(3) == 0) ? ($urandom & 32'h7FFF_FFFF)
                                       : $urandom_range(200000, 1400000);
         set_regs(bx, $urandom_range(200000, 1400000), $urandom_range(200000, 1400000),
                  ($urandom_range(7) == 0) ? ($urandom & 32'h7FFF_FFFF)
                                           : $urandom_range(1000, 40000),
                  $urandom_range(1, 300), n);
         repeat (3) run_frame(n, 1);
      end

      go_idle();
      if (hist_chk.failures == 0 && hist_chk.awaited() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
